### rtl/core/clns_pkg.sv
`timescale 1ns / 1ps

package clns_pkg;

   // Input word: one request to the sequencer.
   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] char_code;
      logic       is_data;
      logic [6:0] delay_units;
      logic [4:0] cell_index;
   } req_type;

   // Result word: pin levels and cached state after one request.
   typedef struct packed {
      logic       accepted;
      logic       rs_pin;
      logic       en_pin;
      logic [3:0] data_pins;
      logic [9:0] queue_count;
      logic       cursor_line;
      logic [7:0] cursor_column;
      logic [7:0] cell_char;
   } rsp_type;

   // Microcode steps. The four request handlers sit in consecutive slots
   // starting at S_QUEUE so that the dispatch step can jump on base plus cmd.
   typedef enum logic [2:0] {
      S_IDLE      = 3'd0,
      S_DISPATCH  = 3'd1,
      S_QUEUE     = 3'd2,
      S_TICK_RD   = 3'd3,
      S_CELL      = 3'd4,
      S_REPORT    = 3'd5,
      S_TICK_EXEC = 3'd6
   } step_type;

   // Datapath operation selected by a control word.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_QUEUE,
      OP_READ,
      OP_TICK,
      OP_CELL,
      OP_REPORT
   } op_type;

   // Jump condition of a control word.
   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_START,
      COND_EMPTY,
      COND_CMD
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target_t;
      step_type target_f;
   } ucode_type;

   // Sequencer to datapath.
   typedef struct packed {
      op_type op;
      logic   load;
   } ctrl_type;

   // Datapath to sequencer.
   typedef struct packed {
      logic       empty;
      logic [1:0] cmd;
   } status_type;

   // Phases of one byte on the bus.
   localparam logic [2:0] PH_HIGH      = 3'd0;
   localparam logic [2:0] PH_EN_HIGH_A = 3'd1;
   localparam logic [2:0] PH_EN_LOW_A  = 3'd2;
   localparam logic [2:0] PH_LOW       = 3'd3;
   localparam logic [2:0] PH_EN_HIGH_B = 3'd4;
   localparam logic [2:0] PH_LATCH     = 3'd5;
   localparam logic [2:0] PH_WAIT      = 3'd6;

   // LCD command bytes tracked by the cache.
   localparam logic [7:0] LCD_CLEAR       = 8'h01;
   localparam logic [7:0] LCD_SHIFT_RIGHT = 8'h14;
   localparam logic [7:0] LCD_SHIFT_LEFT  = 8'h10;
   localparam logic [7:0] LCD_LINE0       = 8'h80;
   localparam logic [7:0] LCD_LINE1       = 8'hC0;

   localparam logic [7:0] COLUMN_LIMIT = 8'd16;
   localparam int         CACHE_CELLS  = 32;
   localparam logic [6:0] FORCED_DELAY = 7'd1;
   localparam logic [7:0] SCALE_RESET  = 8'd1;

   // Control store: one word per step.
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type uw;
      case (step)
         S_IDLE: begin
            uw = '{op: OP_NONE, cond: COND_START, target_t: S_DISPATCH, target_f: S_IDLE};
         end
         S_DISPATCH: begin
            uw = '{op: OP_NONE, cond: COND_CMD, target_t: S_QUEUE, target_f: S_REPORT};
         end
         S_QUEUE: begin
            uw = '{op: OP_QUEUE, cond: COND_ALWAYS, target_t: S_REPORT, target_f: S_REPORT};
         end
         S_TICK_RD: begin
            uw = '{op: OP_READ, cond: COND_EMPTY, target_t: S_REPORT, target_f: S_TICK_EXEC};
         end
         S_TICK_EXEC: begin
            uw = '{op: OP_TICK, cond: COND_ALWAYS, target_t: S_REPORT, target_f: S_REPORT};
         end
         S_CELL: begin
            uw = '{op: OP_CELL, cond: COND_ALWAYS, target_t: S_REPORT, target_f: S_REPORT};
         end
         S_REPORT: begin
            uw = '{op: OP_REPORT, cond: COND_ALWAYS, target_t: S_IDLE, target_f: S_IDLE};
         end
         default: begin
            uw = '{op: OP_NONE, cond: COND_ALWAYS, target_t: S_IDLE, target_f: S_IDLE};
         end
      endcase
      return uw;
   endfunction

endpackage

### rtl/core/char_lcd_nibble_sequencer_unit.sv
`timescale 1ns / 1ps
// Channel   Ports                       Direction  Handshake
// request   start, busy, req_item       in         taken when start && !busy
// result    rsp_valid, rsp_item         out        one-cycle strobe, always taken
// config    csr_we, csr_wdata           in         written when csr_we is high
//
// One request at a time; a queue, cell or empty-tick request passes dispatch,
// its handler step and report; a tick on a non-empty queue adds the tick step
// after the registered FIFO read, and an unused code runs dispatch and report.
// Reset is synchronous; it empties the queue, clears the cache and drives all
// pins low. The result is shown in the last busy cycle and is never held.

module char_lcd_nibble_sequencer_unit
   import clns_pkg::*;
#(
   parameter int QUEUE_DEPTH = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_item,
   output logic       rsp_valid,
   output rsp_type    rsp_item,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);

   ctrl_type   ctrl;
   status_type status;

   // Microcode sequencer.
   clns_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .ctrl   (ctrl)
   );

   // FIFO, bus phases, cursor and text cache.
   clns_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .status    (status),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

### rtl/core/clns_ram.sv
`timescale 1ns / 1ps

module clns_ram #(
   parameter int  WIDTH = 16,
   parameter int  DEPTH = 1024,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/clns_sequencer.sv
`timescale 1ns / 1ps

module clns_sequencer
   import clns_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output ctrl_type   ctrl
);

   step_type  step_ff;
   step_type  step_in;
   ucode_type uw;

   assign uw = ucode_rom(step_ff);

   // Next step from the jump condition of the current control word.
   always_comb begin
      case (uw.cond)
         COND_ALWAYS: begin
            step_in = uw.target_t;
         end
         COND_START: begin
            step_in = start ? uw.target_t : uw.target_f;
         end
         COND_EMPTY: begin
            step_in = status.empty ? uw.target_t : uw.target_f;
         end
         COND_CMD: begin
            // Jump table: handler base plus the request code.
            step_in = step_type'(3'(uw.target_t) + {1'b0, status.cmd});
         end
         default: begin
            step_in = uw.target_f;
         end
      endcase
   end

   // Control outputs to the datapath.
   always_comb begin
      ctrl.op   = uw.op;
      ctrl.load = (uw.cond == COND_START) && start;
      busy      = (step_ff != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### rtl/core/clns_datapath.sv
`timescale 1ns / 1ps

module clns_datapath
   import clns_pkg::*;
#(
   parameter int QUEUE_DEPTH = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  ctrl_type   ctrl,
   output status_type status,
   input  req_type    req_item,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   output logic       rsp_valid,
   output rsp_type    rsp_item
);

   localparam int             PW   = $clog2(QUEUE_DEPTH);
   localparam int             LW   = PW + 1;
   localparam logic [PW-1:0]  LAST = PW'(QUEUE_DEPTH - 1);
   localparam logic [LW-1:0]  FULL_LEN = LW'(QUEUE_DEPTH);
   localparam logic [LW-1:0]  HALF_LEN = LW'(QUEUE_DEPTH / 2);

   // State registers.
   req_type       req_ff;
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic          drain_ff, drain_in;
   logic [2:0]    phase_ff, phase_in;
   logic [14:0]   wait_ff, wait_in;
   logic          forced_valid_ff, forced_valid_in;
   logic [15:0]   forced_word_ff, forced_word_in;
   logic          line_ff, line_in;
   logic [7:0]    column_ff, column_in;
   logic [7:0]    cache_ff [CACHE_CELLS];
   logic [7:0]    cache_in [CACHE_CELLS];
   logic          rs_ff, rs_in;
   logic          en_ff, en_in;
   logic [3:0]    data_ff, data_in;
   logic [7:0]    scale_ff;
   logic          acc_ff, acc_in;
   logic [7:0]    cell_ff, cell_in;

   // Datapath signals.
   logic [PW-1:0] head_next, tail_next;
   logic [LW-1:0] len;
   logic          full;
   logic          may_push;
   logic [6:0]    push_delay;
   logic [15:0]   push_word;
   logic [15:0]   ram_q;
   logic [15:0]   word;
   logic [7:0]    byte_val;
   logic          is_char;
   logic [14:0]   prod;
   logic [7:0]    cache_idx;
   logic          redirect;

   // Word FIFO storage.
   clns_ram #(
      .WIDTH (16),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo_ram (
      .clock (clock),
      .we    ((ctrl.op == OP_QUEUE) && may_push),
      .waddr (tail_ff),
      .wdata (push_word),
      .re    (ctrl.op == OP_READ),
      .raddr (head_ff),
      .rdata (ram_q)
   );

   // Pointer arithmetic and fill level.
   assign head_next = (head_ff == LAST) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == LAST) ? '0 : tail_ff + 1'b1;
   assign len       = (tail_ff >= head_ff) ? (LW'(tail_ff) - LW'(head_ff))
                                           : (FULL_LEN - LW'(head_ff) + LW'(tail_ff));
   assign full      = (tail_next == head_ff);
   assign may_push  = !full && !drain_ff;

   // Queued word: delay in the top bits, zero delay stored as one.
   assign push_delay = (req_ff.delay_units == 7'd0) ? 7'd1 : req_ff.delay_units;
   assign push_word  = {push_delay, req_ff.is_data, req_ff.char_code};

   // Word on the bus and its fields.
   assign word      = forced_valid_ff ? forced_word_ff : ram_q;
   assign byte_val  = word[7:0];
   assign is_char   = word[8];
   assign prod      = {8'd0, word[15:9]} * {7'd0, scale_ff};
   assign cache_idx = {3'b000, line_ff, 4'b0000} + column_ff;
   assign redirect  = is_char && (column_ff >= COLUMN_LIMIT);

   // Next-state logic for queue, tick and cell operations.
   always_comb begin
      head_in         = head_ff;
      tail_in         = tail_ff;
      drain_in        = drain_ff;
      phase_in        = phase_ff;
      wait_in         = wait_ff;
      forced_valid_in = forced_valid_ff;
      forced_word_in  = forced_word_ff;
      line_in         = line_ff;
      column_in       = column_ff;
      cache_in        = cache_ff;
      rs_in           = rs_ff;
      en_in           = en_ff;
      data_in         = data_ff;
      acc_in          = acc_ff;
      cell_in         = cell_ff;

      if (ctrl.load) begin
         acc_in  = 1'b0;
         cell_in = 8'd0;
      end

      case (ctrl.op)
         OP_QUEUE: begin
            if (may_push) begin
               tail_in = tail_next;
               acc_in  = 1'b1;
            end
         end
         OP_CELL: begin
            cell_in = cache_ff[req_ff.cell_index];
         end
         OP_TICK: begin
            // Drain flag: set when full, cleared below half.
            if (full) begin
               drain_in = 1'b1;
            end else if (len < HALF_LEN) begin
               drain_in = 1'b0;
            end

            if (phase_ff == PH_HIGH) begin
               wait_in = (prod == 15'd0) ? 15'd1 : prod;
            end

            if ((phase_ff == PH_HIGH) && redirect) begin
               // Character past the last column: move to the other line first.
               forced_word_in  = {FORCED_DELAY, 1'b0, line_ff ? LCD_LINE0 : LCD_LINE1};
               forced_valid_in = 1'b1;
               phase_in        = PH_HIGH;
            end else begin
               case (phase_ff)
                  PH_HIGH: begin
                     rs_in   = is_char;
                     data_in = byte_val[7:4];
                  end
                  PH_LOW: begin
                     data_in = byte_val[3:0];
                  end
                  PH_EN_HIGH_A, PH_EN_HIGH_B: begin
                     en_in = 1'b1;
                  end
                  PH_EN_LOW_A: begin
                     en_in = 1'b0;
                  end
                  PH_LATCH: begin
                     en_in = 1'b0;
                     // Final latch: keep the text cache and cursor in step.
                     if (is_char) begin
                        if (cache_idx[7:5] == 3'b000) begin
                           cache_in[cache_idx[4:0]] = byte_val;
                        end
                        column_in = column_ff + 8'd1;
                     end else if (byte_val == LCD_CLEAR) begin
                        cache_in  = '{default: '0};
                        line_in   = 1'b0;
                        column_in = 8'd0;
                     end else if (byte_val == LCD_SHIFT_RIGHT) begin
                        column_in = column_ff + 8'd1;
                     end else if (byte_val == LCD_SHIFT_LEFT) begin
                        column_in = column_ff - 8'd1;
                     end else if ((byte_val[7:4] == LCD_LINE0[7:4])
                                  || (byte_val[7:4] == LCD_LINE1[7:4])) begin
                        line_in   = (byte_val[7:4] == LCD_LINE1[7:4]);
                        column_in = {4'd0, byte_val[3:0]};
                     end
                  end
                  default: begin
                  end
               endcase

               // Phase advance, wait countdown and pop.
               if ((phase_ff == PH_WAIT) && (wait_ff != 15'd0)) begin
                  wait_in = wait_ff - 15'd1;
               end else if (phase_ff >= PH_WAIT) begin
                  phase_in = PH_HIGH;
                  if (forced_valid_ff) begin
                     forced_valid_in = 1'b0;
                  end else begin
                     head_in = head_next;
                  end
               end else begin
                  phase_in = phase_ff + 3'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Request latch and configuration register.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         req_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_we) begin
         scale_ff <= csr_wdata;
      end
   end

   // Sequencer state, cache and pins.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff         <= '0;
         tail_ff         <= '0;
         drain_ff        <= 1'b0;
         phase_ff        <= PH_HIGH;
         wait_ff         <= 15'd0;
         forced_valid_ff <= 1'b0;
         forced_word_ff  <= 16'd0;
         line_ff         <= 1'b0;
         column_ff       <= 8'd0;
         cache_ff        <= '{default: '0};
         rs_ff           <= 1'b0;
         en_ff           <= 1'b0;
         data_ff         <= 4'd0;
         acc_ff          <= 1'b0;
         cell_ff         <= 8'd0;
      end else begin
         head_ff         <= head_in;
         tail_ff         <= tail_in;
         drain_ff        <= drain_in;
         phase_ff        <= phase_in;
         wait_ff         <= wait_in;
         forced_valid_ff <= forced_valid_in;
         forced_word_ff  <= forced_word_in;
         line_ff         <= line_in;
         column_ff       <= column_in;
         cache_ff        <= cache_in;
         rs_ff           <= rs_in;
         en_ff           <= en_in;
         data_ff         <= data_in;
         acc_ff          <= acc_in;
         cell_ff         <= cell_in;
      end
   end

   // Status back to the sequencer.
   assign status.empty = (head_ff == tail_ff);
   assign status.cmd   = req_ff.cmd;

   // Result word, shown during the report step.
   assign rsp_valid              = (ctrl.op == OP_REPORT);
   assign rsp_item.accepted      = acc_ff;
   assign rsp_item.rs_pin        = rs_ff;
   assign rsp_item.en_pin        = en_ff;
   assign rsp_item.data_pins     = data_ff;
   assign rsp_item.queue_count   = 10'(len);
   assign rsp_item.cursor_line   = line_ff;
   assign rsp_item.cursor_column = column_ff;
   assign rsp_item.cell_char     = cell_ff;

endmodule

### rtl/core/clns_checker.sv
`timescale 1ns / 1ps

module clns_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // A result word only appears while a request is in progress.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result strobe while not busy");

   // An accepted request makes the block busy.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // Each request gives a single-cycle strobe.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // The block is free again straight after its result.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !busy)
      else $error("block still busy after its result");

   // Reset leaves the block idle with no result.
   assert property (@(posedge clock) reset |=> (!busy && !rsp_valid))
      else $error("block not idle after reset");

endmodule

bind char_lcd_nibble_sequencer_unit clns_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

### dv/char_lcd_nibble_sequencer_unit_tb.sv
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_unit_tb;
   import clns_pkg::*;

   localparam int DEPTH        = 1024;
   localparam int STALL_LIMIT  = 2000;
   localparam int IDLE_GUARD   = 8;
   localparam int END_GUARD    = 20;
   localparam int PHASE_WORDS  = 40;
   localparam int REQ_BITS     = $bits(req_type);

   // Request codes carried in the cmd field.
   localparam logic [1:0] REQ_QUEUE  = 2'd0;
   localparam logic [1:0] REQ_TICK   = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_item;
   logic       rsp_valid;
   rsp_type    rsp_item;
   logic       csr_we;
   logic [7:0] csr_wdata;

   int  errors  = 0;
   bit  idle_en = 1'b1;
   int  stall_cycles;

   rsp_type pending_status [$];
   rsp_type status_want;

   // Shadow copy of the sequencer state.
   logic [15:0] word_mem [DEPTH];
   int          rd_ptr         = 0;
   int          wr_ptr         = 0;
   bit          draining       = 1'b0;
   logic [2:0]  bus_phase      = PH_HIGH;
   int          wait_cnt       = 0;
   bit          forced_pending = 1'b0;
   logic [15:0] forced_w       = '0;
   logic        line_q         = 1'b0;
   logic [7:0]  col_q          = '0;
   logic [7:0]  cache_q [CACHE_CELLS] = '{default: 8'h00};
   logic        pin_rs_q       = 1'b0;
   logic        pin_en_q       = 1'b0;
   logic [3:0]  pin_d_q        = '0;
   logic [7:0]  scale_q        = SCALE_RESET;

   char_lcd_nibble_sequencer_unit #(
      .QUEUE_DEPTH(DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   // Free-running clock.
   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic int slot_after(input int i);
      return (i + 1 >= DEPTH) ? 0 : i + 1;
   endfunction

   function automatic int fifo_fill();
      return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : DEPTH - rd_ptr + wr_ptr;
   endfunction

   function automatic bit fifo_is_full();
      return slot_after(wr_ptr) == rd_ptr;
   endfunction

   // Applies one request word to the shadow state and returns the status it reports.
   function automatic rsp_type predict_status(input req_type r);
      rsp_type     o;
      logic [15:0] w;
      logic [7:0]  b;
      logic [7:0]  idx;
      logic [6:0]  d;
      bit          is_char;
      bit          redirect;
      o        = '0;
      redirect = 1'b0;
      if (r.cmd == REQ_QUEUE) begin
         if (!fifo_is_full() && !draining) begin
            d = (r.delay_units == 7'd0) ? 7'd1 : r.delay_units;
            word_mem[wr_ptr] = {d, r.is_data, r.char_code};
            wr_ptr = slot_after(wr_ptr);
            o.accepted = 1'b1;
         end
      end else if (r.cmd == REQ_TICK && rd_ptr != wr_ptr) begin
         if (fifo_is_full())
            draining = 1'b1;
         else if (fifo_fill() < DEPTH / 2)
            draining = 1'b0;
         w       = forced_pending ? forced_w : word_mem[rd_ptr];
         b       = w[7:0];
         is_char = w[8];
         if (bus_phase == PH_HIGH) begin
            wait_cnt = int'(w[15:9]) * int'(scale_q);
            if (wait_cnt == 0)
               wait_cnt = 1;
            redirect = is_char && (col_q >= COLUMN_LIMIT);
         end
         if (redirect) begin
            // A character past the last column first moves the cursor to the other line.
            forced_w       = {FORCED_DELAY, 1'b0, line_q ? LCD_LINE0 : LCD_LINE1};
            forced_pending = 1'b1;
            bus_phase      = PH_HIGH;
         end else begin
            case (bus_phase)
               PH_HIGH: begin
                  pin_rs_q = is_char;
                  pin_d_q  = b[7:4];
               end
               PH_LOW: begin
                  pin_d_q = b[3:0];
               end
               PH_EN_HIGH_A, PH_EN_HIGH_B: begin
                  pin_en_q = 1'b1;
               end
               PH_EN_LOW_A: begin
                  pin_en_q = 1'b0;
               end
               PH_LATCH: begin
                  // The cache follows the byte on its final latch.
                  if (is_char) begin
                     idx = {3'b000, line_q, 4'b0000} + col_q;
                     if (idx < 8'(CACHE_CELLS))
                        cache_q[idx[4:0]] = b;
                     col_q = col_q + 8'd1;
                  end else if (b == LCD_CLEAR) begin
                     foreach (cache_q[i])
                        cache_q[i] = 8'h00;
                     line_q = 1'b0;
                     col_q  = 8'd0;
                  end else if (b == LCD_SHIFT_RIGHT) begin
                     col_q = col_q + 8'd1;
                  end else if (b == LCD_SHIFT_LEFT) begin
                     col_q = col_q - 8'd1;
                  end else if (b[7:4] == LCD_LINE0[7:4] || b[7:4] == LCD_LINE1[7:4]) begin
                     line_q = (b[7:4] == LCD_LINE1[7:4]);
                     col_q  = {4'h0, b[3:0]};
                  end
                  pin_en_q = 1'b0;
               end
               default: begin
               end
            endcase
            if (bus_phase == PH_WAIT && wait_cnt > 0) begin
               wait_cnt--;
            end else if (bus_phase >= PH_WAIT) begin
               bus_phase = PH_HIGH;
               if (forced_pending)
                  forced_pending = 1'b0;
               else
                  rd_ptr = slot_after(rd_ptr);
            end else begin
               bus_phase = bus_phase + 3'd1;
            end
         end
      end else if (r.cmd == REQ_READ) begin
         o.cell_char = cache_q[r.cell_index];
      end
      o.rs_pin        = pin_rs_q;
      o.en_pin        = pin_en_q;
      o.data_pins     = pin_d_q;
      o.queue_count   = 10'(fifo_fill());
      o.cursor_line   = line_q;
      o.cursor_column = col_q;
      return o;
   endfunction

   // Sends one request word, with an occasional idle burst before it.
   task automatic send_req(input req_type r);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_status.push_back(predict_status(r));
   endtask

   task automatic queue_byte(input logic [7:0] code, input logic dat, input logic [6:0] dly);
      req_type r;
      r             = REQ_BITS'($urandom);
      r.cmd         = REQ_QUEUE;
      r.char_code   = code;
      r.is_data     = dat;
      r.delay_units = dly;
      send_req(r);
   endtask

   task automatic read_cell(input logic [4:0] cell_sel);
      req_type r;
      r            = REQ_BITS'($urandom);
      r.cmd        = REQ_READ;
      r.cell_index = cell_sel;
      send_req(r);
   endtask

   task automatic plain_req(input logic [1:0] code);
      req_type r;
      r     = REQ_BITS'($urandom);
      r.cmd = code;
      send_req(r);
   endtask

   // Ticks until every queued byte has gone out on the bus.
   task automatic tick_until_empty();
      while (rd_ptr != wr_ptr)
         plain_req(REQ_TICK);
   endtask

   // Waits for the last status word and a little more before touching the register.
   task automatic write_scale(input logic [7:0] value);
      start <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (IDLE_GUARD) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      scale_q    = value;
   endtask

   // Random request word, biased towards well-formed byte streams.
   function automatic req_type random_req();
      req_type r;
      int      sel;
      int      pick;
      r   = REQ_BITS'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 22) begin
         r.cmd = REQ_QUEUE;
         pick  = $urandom_range(0, 99);
         r.is_data = (pick < 55);
         if (pick < 55)
            r.char_code = 8'($urandom);
         else if (pick < 58)
            r.char_code = LCD_CLEAR;
         else if (pick < 68)
            r.char_code = LCD_SHIFT_RIGHT;
         else if (pick < 76)
            r.char_code = LCD_SHIFT_LEFT;
         else if (pick < 84)
            r.char_code = LCD_LINE0 | 8'($urandom_range(0, 15));
         else if (pick < 92)
            r.char_code = LCD_LINE1 | 8'($urandom_range(0, 15));
         if (scale_q != 8'd0 && $urandom_range(0, 49) != 0)
            r.delay_units = 7'($urandom_range(0, 2));
      end else if (sel < 86) begin
         r.cmd = REQ_TICK;
      end else if (sel < 97) begin
         r.cmd = REQ_READ;
      end else begin
         r.cmd = REQ_UNUSED;
      end
      return r;
   endfunction

   // Checks one field of a status word against its prediction.
   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_status.size() == 0) begin
            $display("%0t: status word with nothing expected: actual %0h", $time, rsp_item);
            errors++;
         end else begin
            status_want = pending_status.pop_front();
            check_field("accepted", 16'(status_want.accepted), 16'(rsp_item.accepted));
            check_field("rs_pin", 16'(status_want.rs_pin), 16'(rsp_item.rs_pin));
            check_field("en_pin", 16'(status_want.en_pin), 16'(rsp_item.en_pin));
            check_field("data_pins", 16'(status_want.data_pins), 16'(rsp_item.data_pins));
            check_field("queue_count", 16'(status_want.queue_count),
                        16'(rsp_item.queue_count));
            check_field("cursor_line", 16'(status_want.cursor_line),
                        16'(rsp_item.cursor_line));
            check_field("cursor_column", 16'(status_want.cursor_column),
                        16'(rsp_item.cursor_column));
            check_field("cell_char", 16'(status_want.cell_char), 16'(rsp_item.cell_char));
         end
      end
   end

   // Ends the run if no word moves on either channel for too long.
   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid === 1'b1)
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("%0t: watchdog expired with %0d status words outstanding",
               $time, pending_status.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // State straight after reset, an empty tick and the unused code.
   task automatic test_reset_state();
      read_cell(5'd0);
      read_cell(5'd31);
      plain_req(REQ_TICK);
      plain_req(REQ_UNUSED);
   endtask

   // Cursor commands, cache clear, line wrap and field extremes.
   task automatic test_cache_commands();
      queue_byte(8'h00, 1'b1, 7'd0);
      queue_byte(8'hFF, 1'b1, 7'd127);
      queue_byte(LCD_CLEAR, 1'b0, 7'd1);
      queue_byte(8'h41, 1'b1, 7'd2);
      queue_byte(LCD_LINE1 | 8'h0F, 1'b0, 7'd1);
      queue_byte(8'h78, 1'b1, 7'd1);
      // The next character lands past column 15 and is redirected to line 0.
      queue_byte(8'h79, 1'b1, 7'd1);
      tick_until_empty();
      read_cell(5'd31);
      read_cell(5'd0);
      queue_byte(LCD_SHIFT_LEFT, 1'b0, 7'd1);
      queue_byte(LCD_SHIFT_LEFT, 1'b0, 7'd1);
      // Column has wrapped to 255, so this character is redirected to line 1.
      queue_byte(8'h7A, 1'b1, 7'd1);
      queue_byte(LCD_SHIFT_RIGHT, 1'b0, 7'd1);
      queue_byte(LCD_LINE0 | 8'h0F, 1'b0, 7'd1);
      queue_byte(LCD_LINE1, 1'b0, 7'd1);
      queue_byte(LCD_LINE0, 1'b0, 7'd1);
      queue_byte(8'h90, 1'b0, 7'd1);
      queue_byte(8'hBF, 1'b0, 7'd1);
      queue_byte(8'hD0, 1'b0, 7'd1);
      queue_byte(8'h7F, 1'b0, 7'd1);
      tick_until_empty();
      read_cell(5'd16);
      read_cell(5'd1);
   endtask

   // Wait lengths at the ends of the scale range.
   task automatic test_scale_extremes();
      write_scale(8'd0);
      queue_byte(8'h41, 1'b1, 7'd127);
      tick_until_empty();
      write_scale(8'd255);
      queue_byte(LCD_SHIFT_RIGHT, 1'b0, 7'd1);
      tick_until_empty();
   endtask

   // Fill the queue, then check refusals while full and while draining.
   task automatic test_full_queue();
      int n;
      int head_at;
      write_scale(8'd0);
      while (!fifo_is_full())
         queue_byte(8'($urandom), 1'($urandom), 7'($urandom));
      queue_byte(8'h55, 1'b1, 7'd3);
      queue_byte(8'hAA, 1'b0, 7'd3);
      // Tick until one word leaves: no longer full, but still draining.
      n       = 0;
      head_at = rd_ptr;
      while (rd_ptr == head_at) begin
         plain_req(REQ_TICK);
         n++;
         if (n % 4 == 0)
            queue_byte(8'($urandom), 1'($urandom), 7'($urandom));
      end
      queue_byte(8'h33, 1'b1, 7'd1);
      queue_byte(8'hCC, 1'b1, 7'd1);
      plain_req(REQ_TICK);
   endtask

   // Random request streams under several scale settings.
   task automatic test_random();
      logic [7:0] scales [5] = '{8'd1, 8'd3, 8'd0, 8'd2, 8'd1};
      foreach (scales[p]) begin
         write_scale(scales[p]);
         if (p == 4)
            idle_en = 1'b0;
         repeat (PHASE_WORDS)
            send_req(random_req());
      end
   endtask

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_item  <= '0;
      csr_we    <= 1'b0;
      csr_wdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_cache_commands();
      test_scale_extremes();
      test_random();
      test_full_queue();

      start <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (END_GUARD) @(posedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### files.f
rtl/core/clns_pkg.sv
rtl/core/clns_ram.sv
rtl/core/clns_sequencer.sv
rtl/core/clns_datapath.sv
rtl/core/char_lcd_nibble_sequencer_unit.sv
rtl/core/clns_checker.sv
dv/char_lcd_nibble_sequencer_unit_tb.sv
